>>> rtl/ils_pkg.sv
// Shared types, constants and arithmetic helpers for the iterative learning servo.
// Holds the request and result structs, register indexes and the sequencer state type.
// No dependencies.
package ils_pkg;

    localparam int ILS_PASS_LENGTH = 256;
    localparam int DRIVE_LIMIT     = 800;
    localparam int CFG_INDEX_W     = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_LEARN_GAIN_P = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEARN_GAIN_D = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FB_GAIN_P    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FB_GAIN_D    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LEARN_TARGET = 3'd4;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic               loop_closed;
        logic signed [31:0] commanded_pos;
        logic signed [31:0] measured_pos;
        logic signed [31:0] measured_vel;
    } ils_in_t;

    typedef struct packed {
        logic signed [10:0] drive;
        logic signed [31:0] target_out;
        logic               in_learning;
        logic               table_updated;
    } ils_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_FB_D,
        ST_DRIVE,
        ST_RB_READ,
        ST_RB_MUL_P,
        ST_RB_MUL_D,
        ST_RB_WRITE,
        ST_OUT
    } ils_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < S32_MIN)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Round a Q18.16 value half up to an integer, then clamp to the drive limit.
    function automatic logic signed [10:0] to_drive(input logic signed [33:0] q);
        logic signed [34:0] t;
        logic signed [18:0] r;
        logic signed [10:0] d;
        t = 35'(q) + 35'sd32768;
        r = 19'(t >>> 16);
        if (r > 19'(DRIVE_LIMIT))
        begin
            d = 11'(DRIVE_LIMIT);
        end
        else if (r < 19'(-DRIVE_LIMIT))
        begin
            d = 11'(-DRIVE_LIMIT);
        end
        else
        begin
            d = r[10:0];
        end
        return d;
    endfunction

endpackage

>>> rtl/ils_qmul.sv
// Shared gain multiplier: Q16.16 gain times integer, saturated to 32 bits.
// The raw product is registered and saturated after the register. Depends on ils_pkg.
module ils_qmul (
    input  logic               clk,
    input  logic signed [31:0] gain,
    input  logic signed [31:0] operand,
    output logic signed [31:0] product
);
    import ils_pkg::*;

    logic signed [63:0] prod_next;
    logic signed [63:0] prod_reg;

    assign prod_next = 64'(gain) * 64'(operand);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign product = sat32(prod_reg);

endmodule

>>> rtl/iterative_learning_servo.sv
// Iterative learning servo: one request per servo tick, one result per request.
// Open-loop tick: TICK then OUT. Closed tick: TICK, FB_D, DRIVE, then OUT. A new request is
// taken only after OUT has loaded the result of the last one.
// Last tick of a learning pass adds the table rebuild: a read, then MUL_P, MUL_D, WRITE per
// entry through the single gain multiplier and the two table memories.
// rst_n clears the gain and target registers, pass state and slot counter at once; the
// feed-forward table reads as zero until its first rebuild, so no clearing pass is needed.
module iterative_learning_servo #(
    parameter int PASS_LENGTH = ils_pkg::ILS_PASS_LENGTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ils_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            tick_valid,
    output logic                            tick_ready,
    input  ils_pkg::ils_in_t                tick,
    output logic                            result_valid,
    input  logic                            result_ready,
    output ils_pkg::ils_out_t               result
);
    import ils_pkg::*;

    localparam int AW = $clog2(PASS_LENGTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(PASS_LENGTH - 1);
    localparam logic [AW-1:0] LAST_IDX  = AW'(PASS_LENGTH - 2);

    ils_state_t state_reg, state_next;

    logic signed [31:0] learn_gain_p_reg, learn_gain_d_reg;
    logic signed [31:0] fb_gain_p_reg, fb_gain_d_reg, learn_target_reg;

    ils_in_t            in_reg;
    logic               cur_phase_reg;
    logic               phase_reg;
    logic [AW-1:0]      slot_reg;
    logic [AW-1:0]      idx_reg;
    logic               built_reg;
    logic               upd_reg;
    logic signed [33:0] q_reg;
    logic signed [33:0] acc_reg;
    logic signed [31:0] u_reg, ecur_reg, eprev_reg, diff_reg;
    ils_out_t           result_reg;
    logic               result_valid_reg;

    logic signed [31:0] err_mem [PASS_LENGTH];
    logic signed [31:0] ff_mem  [PASS_LENGTH];
    logic signed [31:0] err_rd_reg, ff_rd_reg;

    logic [AW-1:0]      rd_addr;
    logic               err_we, ff_we, load_result;
    logic signed [31:0] mul_gain, mul_operand, mul_product;
    logic signed [31:0] err_value, neg_pos, ff_tick_value, ff_wdata;
    logic               last_slot;

    ils_qmul u_qmul (
        .clk     (clk),
        .gain    (mul_gain),
        .operand (mul_operand),
        .product (mul_product)
    );

    assign err_value     = sat32(64'(in_reg.commanded_pos) - 64'(in_reg.measured_pos));
    assign neg_pos       = sat32(-64'(in_reg.measured_pos));
    assign last_slot     = (slot_reg == LAST_SLOT);
    assign ff_tick_value = (built_reg && !last_slot) ? ff_rd_reg : 32'sd0;
    assign ff_wdata      = sat32(64'(acc_reg)
                                 + ((idx_reg == '0) ? 64'sd0 : 64'(mul_product)));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_valid)
                begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK:
            begin
                state_next = in_reg.loop_closed ? ST_FB_D : ST_OUT;
            end
            ST_FB_D:
            begin
                state_next = ST_DRIVE;
            end
            ST_DRIVE:
            begin
                state_next = (phase_reg && last_slot) ? ST_RB_READ : ST_OUT;
            end
            ST_RB_READ:
            begin
                state_next = ST_RB_MUL_P;
            end
            ST_RB_MUL_P:
            begin
                state_next = ST_RB_MUL_D;
            end
            ST_RB_MUL_D:
            begin
                state_next = ST_RB_WRITE;
            end
            ST_RB_WRITE:
            begin
                state_next = (idx_reg == LAST_IDX) ? ST_OUT : ST_RB_MUL_P;
            end
            ST_OUT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        tick_ready  = 1'b0;
        err_we      = 1'b0;
        ff_we       = 1'b0;
        load_result = 1'b0;
        rd_addr     = slot_reg;
        mul_gain    = fb_gain_p_reg;
        mul_operand = neg_pos;
        case (state_reg)
            ST_IDLE:
            begin
                tick_ready = 1'b1;
            end
            ST_TICK:
            begin
                err_we = in_reg.loop_closed;
            end
            ST_FB_D:
            begin
                mul_gain    = fb_gain_d_reg;
                mul_operand = in_reg.measured_vel;
            end
            ST_RB_READ, ST_RB_MUL_D:
            begin
                rd_addr     = idx_reg;
                mul_gain    = learn_gain_d_reg;
                mul_operand = diff_reg;
            end
            ST_RB_MUL_P:
            begin
                rd_addr     = idx_reg;
                mul_gain    = learn_gain_p_reg;
                mul_operand = err_rd_reg;
            end
            ST_RB_WRITE:
            begin
                ff_we   = 1'b1;
                rd_addr = idx_reg + 1'b1;
            end
            ST_OUT:
            begin
                load_result = !result_valid_reg || result_ready;
            end
            default:
            begin
                tick_ready = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            learn_gain_p_reg <= '0;
            learn_gain_d_reg <= '0;
            fb_gain_p_reg    <= '0;
            fb_gain_d_reg    <= '0;
            learn_target_reg <= '0;
            phase_reg        <= 1'b1;
            slot_reg         <= '0;
            built_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_LEARN_GAIN_P: learn_gain_p_reg <= cfg_data;
                    REG_LEARN_GAIN_D: learn_gain_d_reg <= cfg_data;
                    REG_FB_GAIN_P:    fb_gain_p_reg    <= cfg_data;
                    REG_FB_GAIN_D:    fb_gain_d_reg    <= cfg_data;
                    REG_LEARN_TARGET: learn_target_reg <= cfg_data;
                    default:          learn_target_reg <= learn_target_reg;
                endcase
            end
            if (state_reg == ST_DRIVE)
            begin
                if (last_slot)
                begin
                    slot_reg  <= '0;
                    phase_reg <= !phase_reg;
                end
                else
                begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end
            if (state_reg == ST_RB_WRITE && idx_reg == LAST_IDX)
            begin
                built_reg <= 1'b1;
            end
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_valid)
                begin
                    in_reg        <= tick;
                    cur_phase_reg <= phase_reg;
                    upd_reg       <= 1'b0;
                    q_reg         <= '0;
                end
            end
            ST_FB_D:
            begin
                acc_reg <= 34'(mul_product);
            end
            ST_DRIVE:
            begin
                q_reg   <= phase_reg ? 34'(ff_tick_value) : acc_reg - 34'(mul_product);
                upd_reg <= phase_reg && last_slot;
                idx_reg <= '0;
            end
            ST_RB_MUL_P:
            begin
                ecur_reg <= err_rd_reg;
                diff_reg <= sat32(64'(err_rd_reg) - 64'(eprev_reg));
                u_reg    <= (built_reg && idx_reg != '0) ? ff_rd_reg : 32'sd0;
            end
            ST_RB_MUL_D:
            begin
                acc_reg <= 34'(u_reg) + 34'(mul_product);
            end
            ST_RB_WRITE:
            begin
                eprev_reg <= ecur_reg;
                idx_reg   <= idx_reg + 1'b1;
            end
            ST_OUT:
            begin
                if (load_result)
                begin
                    result_reg.drive         <= to_drive(q_reg);
                    result_reg.target_out    <= cur_phase_reg ? learn_target_reg : 32'sd0;
                    result_reg.in_learning   <= cur_phase_reg;
                    result_reg.table_updated <= upd_reg;
                end
            end
            default:
            begin
                eprev_reg <= eprev_reg;
            end
        endcase
    end

    // Error and feed-forward tables
    always_ff @(posedge clk)
    begin
        if (err_we)
        begin
            err_mem[slot_reg] <= err_value;
        end
        err_rd_reg <= err_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ff_we)
        begin
            ff_mem[idx_reg] <= ff_wdata;
        end
        ff_rd_reg <= ff_mem[rd_addr];
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !tick_ready)
        else $error("request accepted while another is in progress");

    a_update_in_learning: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.table_updated |-> result.in_learning)
        else $error("table update reported outside a learning pass");

    a_drive_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.drive <= 11'sd800) && (result.drive >= -11'sd800))
        else $error("drive outside saturation limit");

    a_rebuild_in_learning: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRIVE && state_next == ST_RB_READ |=> !phase_reg && slot_reg == '0)
        else $error("rebuild did not start a return pass");

endmodule

>>> dv/ils_tracker_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the iterative learning servo: tracks pass state, error and feed-forward
// tables and gains, and queues the result expected for every accepted request.
// Depends on ils_pkg for the request/result structs and register indexes.
package ils_tracker_pkg;

    import ils_pkg::*;

    localparam int     PASS_LEN  = ILS_PASS_LENGTH;
    localparam longint S32_HI    = 64'sd2147483647;
    localparam longint S32_LO    = -64'sd2147483648;
    localparam longint DRIVE_MAX = 800;

    class servo_tracker;

        int          gain_lp;
        int          gain_ld;
        int          gain_fp;
        int          gain_fd;
        int          target;
        bit          learning;
        int unsigned tick_no;
        int          err_tab [PASS_LEN];
        int          ff_tab [PASS_LEN];
        ils_out_t    awaited [$];
        int          faults;
        int          shown;

        function new();
            gain_lp  = 0;
            gain_ld  = 0;
            gain_fp  = 0;
            gain_fd  = 0;
            target   = 0;
            learning = 1'b1;
            tick_no  = 1;
            foreach (err_tab[i])
            begin
                err_tab[i] = 0;
                ff_tab[i]  = 0;
            end
            faults = 0;
            shown  = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > S32_HI)
            begin
                return S32_HI;
            end
            if (v < S32_LO)
            begin
                return S32_LO;
            end
            return v;
        endfunction

        function longint gain_mul(int gain, longint x);
            return clamp32(longint'(gain) * clamp32(x));
        endfunction

        function logic signed [10:0] drive_of(longint q);
            longint r;
            r = (q + 32768) >>> 16;
            if (r > DRIVE_MAX)
            begin
                r = DRIVE_MAX;
            end
            else if (r < -DRIVE_MAX)
            begin
                r = -DRIVE_MAX;
            end
            return 11'(r);
        endfunction

        function void rebuild_ff();
            longint s;
            ff_tab[0] = int'(gain_mul(gain_lp, err_tab[0]));
            for (int i = 1; i + 1 < PASS_LEN; i++)
            begin
                s = longint'(ff_tab[i]) + gain_mul(gain_lp, err_tab[i])
                  + gain_mul(gain_ld, longint'(err_tab[i]) - longint'(err_tab[i-1]));
                ff_tab[i] = int'(clamp32(s));
            end
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
            case (idx)
                REG_LEARN_GAIN_P: gain_lp = int'(val);
                REG_LEARN_GAIN_D: gain_ld = int'(val);
                REG_FB_GAIN_P:    gain_fp = int'(val);
                REG_FB_GAIN_D:    gain_fd = int'(val);
                REG_LEARN_TARGET: target  = int'(val);
                default: ;
            endcase
        endfunction

        function ils_out_t servo_tick(ils_in_t t);
            ils_out_t    r;
            longint      q;
            int unsigned slot;
            r.drive         = '0;
            r.target_out    = learning ? target : 0;
            r.in_learning   = learning;
            r.table_updated = 1'b0;
            if (t.loop_closed)
            begin
                slot = tick_no - 1;
                err_tab[slot] = int'(clamp32(longint'(t.commanded_pos)
                                             - longint'(t.measured_pos)));
                if (learning)
                begin
                    r.drive = drive_of(longint'(ff_tab[slot]));
                    if (tick_no == PASS_LEN)
                    begin
                        rebuild_ff();
                        r.table_updated = 1'b1;
                        tick_no  = 1;
                        learning = 1'b0;
                    end
                    else
                    begin
                        tick_no++;
                    end
                end
                else
                begin
                    q = gain_mul(gain_fp, -longint'(t.measured_pos))
                      - gain_mul(gain_fd, longint'(t.measured_vel));
                    r.drive = drive_of(q);
                    if (tick_no == PASS_LEN)
                    begin
                        tick_no  = 1;
                        learning = 1'b1;
                    end
                    else
                    begin
                        tick_no++;
                    end
                end
            end
            return r;
        endfunction

        function void note_tick(ils_in_t t);
            awaited.push_back(servo_tick(t));
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        task report(string msg);
            faults++;
            if (shown < 40)
            begin
                $display("%0t mismatch: %s", $time, msg);
                shown++;
            end
        endtask

        task check_result(ils_out_t got);
            ils_out_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("result with no request pending, drive %0d", got.drive));
                return;
            end
            want = awaited.pop_front();
            if (got.drive !== want.drive)
            begin
                report($sformatf("drive got %0d want %0d", got.drive, want.drive));
            end
            if (got.target_out !== want.target_out)
            begin
                report($sformatf("target_out got %0d want %0d",
                                 got.target_out, want.target_out));
            end
            if (got.in_learning !== want.in_learning)
            begin
                report($sformatf("in_learning got %b want %b",
                                 got.in_learning, want.in_learning));
            end
            if (got.table_updated !== want.table_updated)
            begin
                report($sformatf("table_updated got %b want %b",
                                 got.table_updated, want.table_updated));
            end
        endtask

    endclass

endpackage

>>> dv/iterative_learning_servo_test.sv
`timescale 1ns / 100ps
// Top-level testbench for iterative_learning_servo: drives requests and gain settings,
// throttles both handshakes and checks every result against servo_tracker.
// Depends on ils_pkg and ils_tracker_pkg.
module iterative_learning_servo_test;

    import ils_pkg::*;
    import ils_tracker_pkg::*;

    localparam int REBUILD_WAIT = 3 * PASS_LEN + 20;
    localparam int HOLD_CYCLES  = 2000;
    localparam int CONFIG_SETS  = 6;
    localparam int PHASE_ITEMS  = 275;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;
    logic                   tick_valid;
    logic                   tick_ready;
    ils_in_t                tick;
    logic                   result_valid;
    logic                   result_ready;
    ils_out_t               result;

    int           send_idle_pct;
    int           stall_pct;
    int           hold_trigger;
    servo_tracker tracker;

    iterative_learning_servo DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .tick         (tick),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            tracker.check_result(result);
        end
    end

    initial
    begin : receiver
        int seen;
        int left;
        seen         = 0;
        left         = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_trigger != seen)
            begin
                seen = hold_trigger;
                left = HOLD_CYCLES;
            end
            if (left > 0)
            begin
                left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic ils_in_t tick_of(logic closed, logic [31:0] cmd, logic [31:0] pos,
                                        logic [31:0] vel);
        ils_in_t t;
        t.loop_closed   = closed;
        t.commanded_pos = cmd;
        t.measured_pos  = pos;
        t.measured_vel  = vel;
        return t;
    endfunction

    function automatic ils_in_t random_tick();
        ils_in_t t;
        t.loop_closed = ($urandom_range(99) < 92);
        if ($urandom_range(7) == 0)
        begin
            t.commanded_pos = $urandom;
            t.measured_pos  = $urandom;
            t.measured_vel  = $urandom;
        end
        else
        begin
            t.commanded_pos = $urandom_range(4000) - 2000;
            t.measured_pos  = t.commanded_pos + ($urandom_range(600) - 300);
            t.measured_vel  = $urandom_range(1000) - 500;
        end
        return t;
    endfunction

    task automatic pick_idling();
        case ($urandom_range(3))
            0:
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            1:
            begin
                send_idle_pct = 77;
                stall_pct     = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct     = 77;
            end
            default:
            begin
                send_idle_pct = 19;
                stall_pct     = 19;
            end
        endcase
    endtask

    task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        tracker.write_reg(idx, val);
    endtask

    task automatic apply_setting(int k);
        logic [31:0]            v [5];
        logic [CFG_INDEX_W-1:0] ids [5];
        ids = '{REG_LEARN_GAIN_P, REG_LEARN_GAIN_D, REG_FB_GAIN_P, REG_FB_GAIN_D,
                REG_LEARN_TARGET};
        case (k)
            0: v = '{32'd65536, 32'd32768, 32'd16384, 32'd8192, 32'd1000};
            1: v = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
            2: v = '{-32'sd98304, -32'sd65536, -32'sd32768, -32'sd16384, -32'sd12345};
            3: v = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000};
            4: v = '{$urandom_range(131072) - 65536, $urandom_range(131072) - 65536,
                     $urandom_range(65536) - 32768, $urandom_range(65536) - 32768, $urandom};
            default: v = '{32'd32768, 32'd0, 32'd32768, 32'd0, 32'd0};
        endcase
        foreach (ids[i])
        begin
            write_cfg(ids[i], v[i]);
        end
        for (int j = int'(REG_LEARN_TARGET) + 1; j < (1 << CFG_INDEX_W); j++)
        begin
            write_cfg(CFG_INDEX_W'(j), $urandom);
        end
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_tick(ils_in_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tick_valid <= 1'b0;
            @(negedge clk);
        end
        tick_valid <= 1'b1;
        tick       <= t;
        do
            @(posedge clk);
        while (!tick_ready);
        tracker.note_tick(t);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (REBUILD_WAIT) @(negedge clk);
    endtask

    initial
    begin : stimulus
        ils_in_t directed [$];
        tracker       = new();
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        tick_valid    = 1'b0;
        tick          = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_trigger  = 0;
        directed.push_back(tick_of(1'b0, 32'h0, 32'h0, 32'h0));
        directed.push_back(tick_of(1'b0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
        directed.push_back(tick_of(1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        directed.push_back(tick_of(1'b1, 32'h0, 32'h0, 32'h0));
        directed.push_back(tick_of(1'b1, 32'h7FFFFFFF, 32'h80000000, 32'h0));
        directed.push_back(tick_of(1'b1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000));
        directed.push_back(tick_of(1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        directed.push_back(tick_of(1'b1, 32'h80000000, 32'h80000000, 32'h80000000));
        directed.push_back(tick_of(1'b1, 32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF));
        directed.push_back(tick_of(1'b1, 32'd12345, -32'sd54321, 32'd777));
        directed.push_back(tick_of(1'b1, 32'd3, 32'd0, 32'd1));
        directed.push_back(tick_of(1'b1, -32'sd3, 32'd0, -32'sd1));
        directed.push_back(tick_of(1'b0, 32'h55555555, 32'hAAAAAAAA, 32'h5A5A5A5A));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        apply_setting(0);
        foreach (directed[i])
        begin
            send_tick(directed[i]);
        end

        for (int ph = 0; ph < CONFIG_SETS; ph++)
        begin
            if (ph > 0)
            begin
                tick_valid <= 1'b0;
                wait_drained();
                apply_setting(ph);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 40 == 0)
                begin
                    pick_idling();
                end
                if (n == 100 && (ph == 1 || ph == 4))
                begin
                    hold_trigger++;
                end
                send_tick(random_tick());
            end
        end
        tick_valid <= 1'b0;
        wait_drained();

        if (tracker.faults == 0)
        begin
            $display("iterative_learning_servo regression: pass");
        end
        else
        begin
            $display("iterative_learning_servo regression: fail");
        end
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("iterative_learning_servo regression: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/ils_pkg.sv
rtl/ils_qmul.sv
rtl/iterative_learning_servo.sv
dv/ils_tracker_pkg.sv
dv/iterative_learning_servo_test.sv
